@@ src/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the sequenced fragment reassembler
// ----------------------------------------------------------------------------
package sfr_pkg;

  // depth of the packet store in bytes
  localparam int BUF_DEPTH = 2048;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  // a length can reach the full depth
  localparam int LEN_W     = ADDR_W + 1;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_DISCARD  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_READ     = 3'd4
  } status_t;

  typedef enum logic {
    OP_FRAGMENT = 1'b0,
    OP_READ     = 1'b1
  } opcode_t;

  typedef struct packed {
    logic first;
    logic last;
  } kind_t;

  typedef struct packed {
    opcode_t     opcode;
    logic        has_byte;
    logic [7:0]  payload_byte;
    logic        fragment_end;
    logic [31:0] frag_seq;
    logic [2:0]  seq_width_bytes;
    logic        first_flag;
    logic        last_flag;
    logic [10:0] read_index;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [11:0] packet_length;
    logic        rd_ok;
    logic        seq_mismatch;
  } res_t;

endpackage

@@ src/sfr_req_if.sv @@
// ----------------------------------------------------------------------------
// sfr_req_if
// input channel: fragment items and read requests
// ----------------------------------------------------------------------------
interface sfr_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        has_byte;
  logic [7:0]  payload_byte;
  logic        fragment_end;
  logic [31:0] frag_seq;
  logic [2:0]  seq_width_bytes;
  logic        first_flag;
  logic        last_flag;
  logic [10:0] read_index;

  modport source (
    output valid, opcode, has_byte, payload_byte, fragment_end, frag_seq,
           seq_width_bytes, first_flag, last_flag, read_index,
    input  ready
  );

  modport sink (
    input  valid, opcode, has_byte, payload_byte, fragment_end, frag_seq,
           seq_width_bytes, first_flag, last_flag, read_index,
    output ready
  );
endinterface

@@ src/sfr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sfr_rsp_if
// output channel: one result item per input item
// ----------------------------------------------------------------------------
interface sfr_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] packet_length;
  logic [7:0]  read_byte;
  logic        seq_mismatch;

  modport source (
    output valid, status, packet_length, read_byte, seq_mismatch,
    input  ready
  );

  modport sink (
    input  valid, status, packet_length, read_byte, seq_mismatch,
    output ready
  );
endinterface

@@ src/sfr_ram.sv @@
// ----------------------------------------------------------------------------
// sfr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/sfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfr_ctrl
// fragment state tracking, store addressing and result decode
// ----------------------------------------------------------------------------
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  item_t             item,
  output res_t              res,
  output logic              we,
  output logic [ADDR_W-1:0] waddr,
  output logic [7:0]        wdata,
  output logic              re,
  output logic [ADDR_W-1:0] raddr
);

  logic [31:0]      expected_seq, expected_seq_next;
  logic             partial_active, partial_active_next;
  logic [LEN_W-1:0] partial_length, partial_length_next;
  logic             mid_fragment, mid_fragment_next;
  kind_t            fragment_kind, fragment_kind_next;
  logic             discarding, discarding_next;
  logic [LEN_W-1:0] completed_length, completed_length_next;

  function automatic logic [31:0] wrap_mask(input logic [2:0] w);
    logic [31:0] m;
    case (w) inside
      [3'd0:3'd1]: m = 32'h0000_00ff;
      3'd2:        m = 32'h0000_ffff;
      3'd3:        m = 32'h00ff_ffff;
      default:     m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  always_comb begin
    expected_seq_next     = expected_seq;
    partial_active_next   = partial_active;
    partial_length_next   = partial_length;
    mid_fragment_next     = mid_fragment;
    fragment_kind_next    = fragment_kind;
    discarding_next       = discarding;
    completed_length_next = completed_length;

    res.status        = ST_STORED;
    res.packet_length = '0;
    res.rd_ok         = 1'b0;
    res.seq_mismatch  = 1'b0;

    we    = 1'b0;
    waddr = partial_length[ADDR_W-1:0];
    wdata = item.payload_byte;
    re    = 1'b0;
    raddr = ADDR_W'(item.read_index);

    if (item.opcode == OP_READ) begin
      // read back of the completed packet, state untouched
      res.status = ST_READ;
      res.rd_ok  = (32'(item.read_index) < 32'(completed_length)) &&
                   (32'(item.read_index) < BUF_DEPTH);
      re         = accept;
    end else begin
      // header of a fragment is taken from its first item
      if (!mid_fragment) begin
        fragment_kind_next = '{first: item.first_flag, last: item.last_flag};
        if (item.frag_seq != expected_seq) begin
          res.seq_mismatch    = 1'b1;
          partial_active_next = 1'b0;
        end
        if (item.first_flag) begin
          partial_active_next   = 1'b1;
          partial_length_next   = '0;
          completed_length_next = '0;
          discarding_next       = 1'b0;
        end else begin
          discarding_next = !partial_active_next;
        end
        expected_seq_next = (item.frag_seq + 32'd1) & wrap_mask(item.seq_width_bytes);
      end

      if (discarding_next) begin
        res.status = ST_DISCARD;
      end else if (item.has_byte) begin
        if (32'(partial_length_next) >= BUF_DEPTH) begin
          partial_active_next = 1'b0;
          discarding_next     = 1'b1;
          res.status          = ST_OVERFLOW;
        end else begin
          we                  = accept;
          waddr               = partial_length_next[ADDR_W-1:0];
          partial_length_next = partial_length_next + LEN_W'(1);
        end
      end

      if (res.status == ST_STORED && item.fragment_end && fragment_kind_next.last) begin
        completed_length_next = partial_length_next;
        partial_active_next   = 1'b0;
        res.status            = ST_COMPLETE;
        res.packet_length     = 12'(partial_length_next);
      end

      mid_fragment_next = !item.fragment_end;
      if (item.fragment_end) begin
        discarding_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq     <= '0;
      partial_active   <= 1'b0;
      partial_length   <= '0;
      mid_fragment     <= 1'b0;
      fragment_kind    <= '0;
      discarding       <= 1'b0;
      completed_length <= '0;
    end else if (accept) begin
      expected_seq     <= expected_seq_next;
      partial_active   <= partial_active_next;
      partial_length   <= partial_length_next;
      mid_fragment     <= mid_fragment_next;
      fragment_kind    <= fragment_kind_next;
      discarding       <= discarding_next;
      completed_length <= completed_length_next;
    end
  end

`ifndef ASSERT_OFF
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> 32'(waddr) < BUF_DEPTH)
    else $error("store write beyond depth");

  a_one_port_op: assert property (@(posedge clk) disable iff (rst)
    !(we && re))
    else $error("write and read issued for the same item");

  a_discard_in_fragment: assert property (@(posedge clk) disable iff (rst)
    !mid_fragment |-> !discarding)
    else $error("discard flag left set between fragments");
`endif

endmodule

@@ src/sequenced_fragment_reassembler_core.sv @@
// ----------------------------------------------------------------------------
// sequenced_fragment_reassembler_core
// reassembles sequenced fragments into one packet store and reads it back
// ----------------------------------------------------------------------------
//
//   channel  dir  contents
//   -------  ---  ----------------------------------------------------------
//   req      in   fragment byte with header fields, or read of a stored byte
//   rsp      out  status, packet length, read byte, sequence mismatch flag
//
// one item is taken per cycle while req.ready is high; its result, with any
// store read, sits in the output register from the following cycle
// the store sees at most one access per item: a write for a stored fragment
// byte, a read for a read item
// req.ready is low only while a result waits in the output register and rsp
// is stalled; reset clears fragment state and output valid, not the store
//
module sequenced_fragment_reassembler_core
  import sfr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  sfr_req_if.sink   req,
  sfr_rsp_if.source rsp
);

  logic              accept;
  item_t             item;
  res_t              res;
  res_t              res_q;      // output register payload
  logic              rsp_valid;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  // output register frees up when its item is taken
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign item = '{
    opcode:          opcode_t'(req.opcode),
    has_byte:        req.has_byte,
    payload_byte:    req.payload_byte,
    fragment_end:    req.fragment_end,
    frag_seq:        req.frag_seq,
    seq_width_bytes: req.seq_width_bytes,
    first_flag:      req.first_flag,
    last_flag:       req.last_flag,
    read_index:      req.read_index
  };

  sfr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .res    (res),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (re),
    .raddr  (raddr)
  );

  // packet store; read data holds until the next read item is taken
  sfr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req.ready) begin
      rsp_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = res_q.status;
  assign rsp.packet_length = res_q.packet_length;
  // out of range reads give zero
  assign rsp.read_byte     = res_q.rd_ok ? rdata : 8'd0;
  assign rsp.seq_mismatch  = res_q.seq_mismatch;

`ifndef ASSERT_OFF
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("accepted item gave no result");

  a_byte_only_on_read: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && res_q.status != ST_READ |-> rsp.read_byte == 8'd0)
    else $error("read byte driven on a fragment result");

  a_length_only_on_complete: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && res_q.status != ST_COMPLETE |-> rsp.packet_length == 12'd0)
    else $error("packet length driven without completion");
`endif

endmodule
